FILE: rtl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned TrigW  = 8;
  localparam int unsigned TmoW   = 16;
  localparam int unsigned ThrW   = 10;
  localparam int unsigned WidthW = 16;
  localparam int unsigned DistW  = 17;
  localparam int unsigned AddrW  = 2;
  localparam int unsigned DataW  = 16;

  // Register indexes on the configuration port.
  localparam logic [AddrW-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [AddrW-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [AddrW-1:0] REG_NEAR_THRESH   = 2'd2;

  // Reset values of the registers.
  localparam logic [TrigW-1:0] TRIG_RESET = 8'd10;
  localparam logic [TmoW-1:0]  TMO_RESET  = 16'd60000;
  localparam logic [ThrW-1:0]  THR_RESET  = 10'd40;

  // width * 17 fits in 21 bits; divide by ten through a reciprocal.
  // ceil(2^24 / 10) overshoots by 4 / 2^24 per unit, exact below 2^22.
  localparam int unsigned ProdW       = 21;
  localparam int unsigned Div10Shift  = 24;
  localparam logic [ProdW-1:0] DIV10_MUL = 21'd1677722;
  localparam logic [ProdW-1:0] CM_SCALE  = 21'd1000;

  typedef struct packed {
    logic [TrigW-1:0] trigger_ticks;
    logic [TmoW-1:0]  timeout_ticks;
    logic [ThrW-1:0]  near_threshold_cm;
  } cfg_t;

  typedef struct packed {
    logic trig;
    logic done;
    logic tmo;
  } flags_t;

endpackage

FILE: rtl/uer_if.sv
// Valid/ready channel interfaces for the input ticks and the result beats.
interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trigger_out;
  logic              measure_done;
  logic [WidthW-1:0] echo_width_us;
  logic [DistW-1:0]  distance_centi_cm;
  logic              obstacle_near;
  logic              timed_out;

  modport source (output valid, output trigger_out, output measure_done,
                  output echo_width_us, output distance_centi_cm,
                  output obstacle_near, output timed_out, input ready);
  modport sink   (input valid, input trigger_out, input measure_done,
                  input echo_width_us, input distance_centi_cm,
                  input obstacle_near, input timed_out, output ready);
endinterface

FILE: rtl/uer_cfg.sv
// Configuration register file of the ultrasonic echo ranger.
module uer_cfg import uer_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks     <= TRIG_RESET;
      cfg_q.timeout_ticks     <= TMO_RESET;
      cfg_q.near_threshold_cm <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TRIGGER_TICKS: cfg_q.trigger_ticks     <= cfg_wdata_i[TrigW-1:0];
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks     <= cfg_wdata_i[TmoW-1:0];
        REG_NEAR_THRESH:   cfg_q.near_threshold_cm <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/uer_fsm.sv
// Trigger, echo wait and echo width state machine, advanced once per tick.
module uer_fsm import uer_pkg::*; #(
  parameter int unsigned CntW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            echo_i,
  input  cfg_t            cfg_i,
  output flags_t          flags_o,
  output logic [CntW-1:0] width_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS
  } phase_e;

  localparam logic [CntW-1:0] WidthMax = {CntW{1'b1}};
  localparam logic [TrigW-1:0] PulseMax = {TrigW{1'b1}};

  phase_e            phase_q, phase_d;
  logic [TrigW-1:0]  pulse_q, pulse_d, pulse_inc;
  logic [TmoW-1:0]   wait_q, wait_d;
  logic [CntW-1:0]   width_q, width_d;
  logic [TrigW-1:0]  pulse_len;
  flags_t            flags;

  // A programmed length of zero behaves as a single tick.
  assign pulse_len = (cfg_i.trigger_ticks == '0) ? TrigW'(1) : cfg_i.trigger_ticks;
  assign pulse_inc = (pulse_q < PulseMax) ? pulse_q + TrigW'(1) : pulse_q;

  always_comb begin
    phase_d = phase_q;
    pulse_d = pulse_q;
    wait_d  = wait_q;
    width_d = width_q;
    flags   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!echo_i) begin
          flags.trig = 1'b1;
          pulse_d    = TrigW'(1);
          if (pulse_len == TrigW'(1)) begin
            phase_d = PH_WAIT;
            wait_d  = '0;
          end else begin
            phase_d = PH_TRIG;
          end
        end
      end
      PH_TRIG: begin
        flags.trig = 1'b1;
        pulse_d    = pulse_inc;
        if (pulse_inc >= pulse_len) begin
          phase_d = PH_WAIT;
          wait_d  = '0;
        end
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_MEAS;
          width_d = CntW'(1);
        end else if (wait_q >= cfg_i.timeout_ticks) begin
          flags.tmo = 1'b1;
          phase_d   = PH_IDLE;
        end else begin
          wait_d = wait_q + TmoW'(1);
        end
      end
      PH_MEAS: begin
        if (echo_i) begin
          if (width_q < WidthMax) begin
            width_d = width_q + CntW'(1);
          end
        end else begin
          flags.done = 1'b1;
          phase_d    = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pulse_q <= '0;
      wait_q  <= '0;
      width_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pulse_q <= pulse_d;
      wait_q  <= wait_d;
      width_q <= width_d;
    end
  end

  assign flags_o = flags;
  assign width_o = width_q;

endmodule

FILE: rtl/uer_range.sv
// Echo width to distance conversion and the near-obstacle compare.
module uer_range import uer_pkg::*; (
  input  logic [WidthW-1:0] width_i,
  input  logic [ThrW-1:0]   thresh_i,
  output logic [DistW-1:0]  dist_o,
  output logic              near_o
);

  logic [ProdW-1:0]   prod17;
  logic [ProdW-1:0]   limit;
  logic [2*ProdW-1:0] recip;

  // width * 17 as a shift and add.
  assign prod17 = ProdW'({width_i, 4'b0000}) + ProdW'(width_i);
  assign recip  = (2*ProdW)'(prod17) * (2*ProdW)'(DIV10_MUL);
  assign dist_o = recip[Div10Shift +: DistW];
  assign limit  = ProdW'(thresh_i) * CM_SCALE;
  assign near_o = (prod17 <= limit);

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Top level: ultrasonic echo ranging controller with valid/ready channels.
// A tick waits in the input register until the result register is free and is
// then processed into it as the offered result beat. Throughput: one tick
// accepted and one result delivered every cycle while the output is ready.
// Reset (rst_ni low, asynchronous) puts the state machine in idle, loads the
// register defaults and clears width, distance and obstacle flag to zero.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  uer_in_if.sink           in_i,
  uer_out_if.source        out_o
);

  // Width counter size: the configured counter, capped at the 16-bit field.
  localparam int unsigned CntW = (COUNT_BITS >= WidthW) ? WidthW : COUNT_BITS;

  cfg_t              cfg;
  flags_t            flags;
  logic [CntW-1:0]   width_cnt;
  logic [WidthW-1:0] width_ext;
  logic [DistW-1:0]  dist_calc;
  logic              near;

  // Input register stage: holds one tick until the result register frees.
  logic s1_valid_q, s1_valid_d;
  logic s1_echo_q;
  logic out_free;
  logic s1_fire;
  logic in_accept;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              trig_q, done_q, tmo_q;
  logic [WidthW-1:0] width_q;
  logic [DistW-1:0]  dist_q;
  logic              near_q;

  uer_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // The result register can take a beat when it is empty or being drained;
  // the input register can then hand over its tick in the same cycle.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_accept  = in_i.valid && in_i.ready;

  // The state machine steps exactly when a tick moves into the result register,
  // so ticks are processed in order with no gaps.
  uer_fsm #(
    .CntW(CntW)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .echo_i (s1_echo_q),
    .cfg_i  (cfg),
    .flags_o(flags),
    .width_o(width_cnt)
  );

  // On the completing tick the width counter holds the measured width.
  assign width_ext = WidthW'(width_cnt);

  uer_range u_range (
    .width_i (width_ext),
    .thresh_i(cfg.near_threshold_cm),
    .dist_o  (dist_calc),
    .near_o  (near)
  );

  assign s1_valid_d  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_echo_q <= in_i.echo_level;
    end
  end

  // The measurement fields live in the result register itself and only load
  // when a measurement completes; they are visible from reset on, so they
  // are reset along with the control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      trig_q      <= 1'b0;
      done_q      <= 1'b0;
      tmo_q       <= 1'b0;
      width_q     <= '0;
      dist_q      <= '0;
      near_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        trig_q <= flags.trig;
        done_q <= flags.done;
        tmo_q  <= flags.tmo;
        if (flags.done) begin
          width_q <= width_ext;
          dist_q  <= dist_calc;
          near_q  <= near;
        end
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.trigger_out       = trig_q;
  assign out_o.measure_done      = done_q;
  assign out_o.echo_width_us     = width_q;
  assign out_o.distance_centi_cm = dist_q;
  assign out_o.obstacle_near     = near_q;
  assign out_o.timed_out         = tmo_q;

endmodule

FILE: rtl/uer_chk.sv
// Port-level checker for the ultrasonic echo ranger and its bind statement.
module uer_chk import uer_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              trig_i,
  input logic              done_i,
  input logic              tmo_i,
  input logic [WidthW-1:0] width_i,
  input logic [DistW-1:0]  dist_i
);

  logic [ProdW-1:0] prod17;
  logic [ProdW-1:0] dist10;

  assign prod17 = ProdW'({width_i, 4'b0000}) + ProdW'(width_i);
  assign dist10 = ProdW'({dist_i, 3'b000}) + ProdW'({dist_i, 1'b0});

  // A tick is in at most one of trigger, completion and timeout.
  a_event_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({trig_i, done_i, tmo_i}))
    else $error("trigger, done and timeout overlap in one beat");

  // The reported distance is always the floor of width * 1.7.
  a_dist_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (dist10 <= prod17) && (prod17 < dist10 + ProdW'(10)))
    else $error("distance does not match echo width");

  // The measurement can only change on a beat that completes a measurement.
  a_meas_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i ##1 out_valid_i && !done_i
      |-> $stable(width_i) || $past(!out_valid_i))
    else $error("width changed without a completed measurement");

  // A stalled beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(width_i) &&
      $stable(trig_i) && $stable(done_i) && $stable(tmo_i))
    else $error("result beat changed while stalled");

endmodule

bind ultrasonic_echo_ranger uer_chk u_uer_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .trig_i     (out_o.trigger_out),
  .done_i     (out_o.measure_done),
  .tmo_i      (out_o.timed_out),
  .width_i    (out_o.echo_width_us),
  .dist_i     (out_o.distance_centi_cm)
);
